/* hdl/ucd_pkg.sv */
// Package for the seconds-to-calendar-date block: shared types and constants.
// Holds the controller state type, the command and status structs and the month table.
// Depends on nothing.
`timescale 1ns / 1ps

package ucd_pkg;

	// Whole days by reciprocal multiplication. 86400 = 128 * 675, and for every n
	// below 2**25, n / 675 equals (n * DAY_RECIP) >> DAY_RECIP_SHIFT.
	localparam int unsigned DAY_SHIFT       = 7;
	localparam logic [25:0] DAY_RECIP       = 26'd50903317;
	localparam int unsigned DAY_RECIP_SHIFT = 35;

	// Epoch year, in binary and as four BCD digits.
	localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
	localparam logic [15:0] EPOCH_YEAR_BCD = 16'h1970;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_YEAR,
		ST_MONTH
	} ucd_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic year_step;
		logic month_step;
		logic emit;
	} ucd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic year_done;
		logic month_done;
	} ucd_status_t;

	// Length of a month given its zero-based index and the leap flag.
	function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
		logic [4:0] len;
		begin
			unique case (idx)
				4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
				4'd1: len = leap ? 5'd29 : 5'd28;
				default: len = 5'd30;
			endcase
			return len;
		end
	endfunction

endpackage

/* hdl/ucd_datapath.sv */
// Datapath of the seconds-to-calendar-date block: day divider, year and month counters.
// Also formats the finished date as numbers and ASCII text.
// Depends on ucd_pkg.
`timescale 1ns / 1ps

module ucd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ucd_pkg::ucd_cmd_t    cmd,
	output ucd_pkg::ucd_status_t status,
	input  logic [31:0]         seconds_since_epoch,
	output logic                done,
	output logic [11:0]         year,
	output logic [3:0]          month,
	output logic [4:0]          day,
	output logic [63:0]         date_text
);

	// Working registers. quo_q holds the second count until the division step,
	// and the remaining day count from then on.
	logic [31:0] quo_q;
	logic [11:0] year_q;
	logic [15:0] year_bcd_q;
	logic [3:0]  mon_idx_q;
	logic        done_q;
	logic [11:0] year_out_q;
	logic [3:0]  month_out_q;
	logic [4:0]  day_out_q;
	logic [63:0] text_out_q;

	logic [50:0] day_prod;
	logic [15:0] days;
	logic        leap;
	logic [4:0]  quad_sum;
	logic [8:0]  diy;
	logic [4:0]  dim;
	logic [3:0]  month_num;
	logic [4:0]  day_num;
	logic [7:0]  month_bcd;
	logic [7:0]  day_bcd;

	// Four-digit BCD increment.
	function automatic logic [15:0] bcd_inc(input logic [15:0] v);
		logic [15:0] r;
		logic        carry;
		begin
			r     = v;
			carry = 1'b1;
			for (int i = 0; i < 4; i++) begin
				if (carry) begin
					if (r[4*i +: 4] == 4'd9) begin
						r[4*i +: 4] = 4'd0;
					end else begin
						r[4*i +: 4] = r[4*i +: 4] + 4'd1;
						carry       = 1'b0;
					end
				end
			end
			return r;
		end
	endfunction

	// Two BCD digits of a value below 40.
	function automatic logic [7:0] to_bcd2(input logic [4:0] v);
		logic [7:0] r;
		begin
			priority if (v >= 5'd30) begin
				r = {4'd3, 4'(v - 5'd30)};
			end else if (v >= 5'd20) begin
				r = {4'd2, 4'(v - 5'd20)};
			end else if (v >= 5'd10) begin
				r = {4'd1, 4'(v - 5'd10)};
			end else begin
				r = {4'd0, v[3:0]};
			end
			return r;
		end
	endfunction

	// Whole days: drop the factor 128 by a shift, then divide by 675 with a
	// reciprocal multiply (25 by 26 bits).
	assign day_prod = 51'(quo_q[31:ucd_pkg::DAY_SHIFT]) * 51'(ucd_pkg::DAY_RECIP);

	assign days = quo_q[15:0];

	// Leap rule from the BCD year: divisible by 4, and not a century unless
	// the century count is divisible by 4 as well.
	assign quad_sum = {year_bcd_q[15:12], 1'b0} + {1'b0, year_bcd_q[11:8]};
	assign leap = (year_q[1:0] == 2'b00) &&
		((year_bcd_q[7:0] != 8'h00) || (quad_sum[1:0] == 2'b00));

	assign diy = leap ? 9'd366 : 9'd365;
	assign dim = ucd_pkg::month_len(mon_idx_q, leap);

	assign status.year_done  = days < {7'd0, diy};
	assign status.month_done = days < {11'd0, dim};

	// The final month and day, as numbers and as decimal digits.
	assign month_num = mon_idx_q + 4'd1;
	assign day_num   = days[4:0] + 5'd1;
	assign month_bcd = to_bcd2({1'b0, month_num});
	assign day_bcd   = to_bcd2(day_num);

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q      <= seconds_since_epoch;
			year_q     <= ucd_pkg::EPOCH_YEAR;
			year_bcd_q <= ucd_pkg::EPOCH_YEAR_BCD;
			mon_idx_q  <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {16'd0, day_prod[ucd_pkg::DAY_RECIP_SHIFT +: 16]};
		end else if (cmd.year_step) begin
			quo_q      <= {16'd0, days - {7'd0, diy}};
			year_q     <= year_q + 12'd1;
			year_bcd_q <= bcd_inc(year_bcd_q);
		end else if (cmd.month_step) begin
			quo_q     <= {16'd0, days - {11'd0, dim}};
			mon_idx_q <= mon_idx_q + 4'd1;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	// Result registers, loaded when the month search ends.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			year_out_q  <= year_q;
			month_out_q <= month_num;
			day_out_q   <= day_num;
			text_out_q  <= {
				8'h30 + {4'd0, year_bcd_q[15:12]}, 8'h30 + {4'd0, year_bcd_q[11:8]},
				8'h30 + {4'd0, year_bcd_q[7:4]},   8'h30 + {4'd0, year_bcd_q[3:0]},
				8'h30 + {4'd0, month_bcd[7:4]},    8'h30 + {4'd0, month_bcd[3:0]},
				8'h30 + {4'd0, day_bcd[7:4]},      8'h30 + {4'd0, day_bcd[3:0]}
			};
		end
	end

	assign done      = done_q;
	assign year      = year_out_q;
	assign month     = month_out_q;
	assign day       = day_out_q;
	assign date_text = text_out_q;

endmodule

/* hdl/ucd_controller.sv */
// Controller of the seconds-to-calendar-date block: sequences division, year and month search.
// Issues commands to the datapath and reads its status.
// Depends on ucd_pkg.
`timescale 1ns / 1ps

module ucd_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ucd_pkg::ucd_status_t status,
	output ucd_pkg::ucd_cmd_t    cmd
);

	ucd_pkg::ucd_state_t state_q;
	ucd_pkg::ucd_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ucd_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ucd_pkg::ST_IDLE: begin
				if (start) state_next = ucd_pkg::ST_DIVIDE;
			end
			ucd_pkg::ST_DIVIDE: begin
				state_next = ucd_pkg::ST_YEAR;
			end
			ucd_pkg::ST_YEAR: begin
				if (status.year_done) state_next = ucd_pkg::ST_MONTH;
			end
			ucd_pkg::ST_MONTH: begin
				if (status.month_done) state_next = ucd_pkg::ST_IDLE;
			end
			default: state_next = ucd_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ucd_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ucd_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ucd_pkg::ST_YEAR: begin
				cmd.year_step = !status.year_done;
			end
			ucd_pkg::ST_MONTH: begin
				cmd.month_step = !status.month_done;
				cmd.emit       = status.month_done;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

/* hdl/unix_seconds_to_calendar_date.sv */
// Top level: converts unsigned Unix seconds to a Gregorian date (year, month, day, ASCII text).
// Joins the controller and the datapath.
// Depends on ucd_pkg, ucd_controller and ucd_datapath.
//
// Usage: drive seconds_since_epoch and raise start. The transfer is taken at the
// clock edge where start is high and busy is low; busy then stays high until the
// conversion ends. One result per transfer appears on year, month, day and
// date_text, marked by done high for exactly one cycle; the result ports hold it until
// the next result. The receiver cannot stall, so the block never waits on it.
// Steps: load, divide by 86400 with a reciprocal multiply, step once per elapsed
// year plus one in the year search and once per elapsed month plus one in the
// month search, then raise done from a register. The largest input falls in
// February 2106. A new transfer is taken the cycle after the month search ends,
// so at most one item is in work at a time.
// Reset (arst_n low) returns the controller to idle and clears done; no result
// of an interrupted conversion is given.
`timescale 1ns / 1ps

module unix_seconds_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] seconds_since_epoch,
	output logic        done,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [63:0] date_text
);

	ucd_pkg::ucd_cmd_t    cmd;
	ucd_pkg::ucd_status_t status;

	// Sequencer.
	ucd_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	// Arithmetic and result registers.
	ucd_datapath u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.seconds_since_epoch (seconds_since_epoch),
		.done                (done),
		.year                (year),
		.month               (month),
		.day                 (day),
		.date_text           (date_text)
	);

endmodule
